### hdl/cpcd_pkg.sv
// Types and constants for the cross pixel to cube direction block.
// No dependencies; every other file imports this package.
package cpcd_pkg;

    localparam int MAX_FACE_SIZE = 1024;
    localparam int FS_W          = 11;
    localparam int SPAN_W        = 25;
    localparam int PIX_W         = 12;
    localparam int OFF_W         = $clog2(MAX_FACE_SIZE);
    localparam int COMP_W        = 26;
    localparam int MAG_W         = 25;
    localparam int SQ_W          = 2 * MAG_W;
    localparam int RT_W          = SQ_W + 1;
    localparam int RT_STEPS      = MAG_W;
    localparam int FRAC_OUT      = 14;
    localparam int DIV_STEPS     = 15;
    localparam int REM_W         = MAG_W + FRAC_OUT + 1;
    localparam int DIR_W         = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 25;

    localparam logic [CFG_IDX_W-1:0] REG_FACE_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SPAN  = 1'd1;

    localparam logic [FS_W-1:0]   FACE_SIZE_RST = 11'd256;
    localparam logic [SPAN_W-1:0] INV_SPAN_RST  = 25'd65793;

    localparam logic signed [COMP_W-1:0] ONE_Q24 = 26'sd16777216;
    localparam logic signed [DIR_W-1:0]  DIR_ONE = 16'sd16384;

    typedef enum logic [2:0] {
        FACE_PX = 3'd0,
        FACE_NX = 3'd1,
        FACE_PY = 3'd2,
        FACE_NY = 3'd3,
        FACE_PZ = 3'd4,
        FACE_NZ = 3'd5
    } face_t;

    typedef struct packed {
        logic                     ok;
        face_t                    face;
        logic signed [COMP_W-1:0] a;
        logic signed [COMP_W-1:0] b;
        logic signed [COMP_W-1:0] c;
    } item_t;

    typedef struct packed {
        logic                       ok;
        face_t                      face;
        logic [2:0]                 neg;
        logic [2:0][MAG_W-1:0]      mag;
    } carry_t;

    typedef struct packed {
        logic       ok;
        face_t      face;
        logic [2:0] neg;
    } tag_t;

endpackage

### hdl/cpcd_if.sv
// Channel interfaces for pixel input and direction output.
// Depends on cpcd_pkg.
interface cpcd_pix_if;
    import cpcd_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pix_x;
    logic [PIX_W-1:0] pix_y;
    modport source (output valid, output pix_x, output pix_y, input ready);
    modport sink   (input valid, input pix_x, input pix_y, output ready);
endinterface

interface cpcd_dir_if;
    import cpcd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    valid_res;
    logic [2:0]              face_code;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    modport source (output valid, output valid_res, output face_code,
                    output dir_x, output dir_y, output dir_z, input ready);
    modport sink   (input valid, input valid_res, input face_code,
                    input dir_x, input dir_y, input dir_z, output ready);
endinterface

### hdl/cpcd_front.sv
// Front end: tile classification and face vector in Q.24.
// Depends on cpcd_pkg and cpcd_if.
module cpcd_front
    import cpcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [FS_W-1:0]   face_size,
    input  logic [SPAN_W-1:0] inv_span,
    cpcd_pix_if.sink          pix,
    output item_t             q_item,
    output logic              q_push,
    input  logic              q_ready
);

    logic             en;
    logic [FS_W-1:0]  w;
    logic [PIX_W-1:0] w2;
    logic [PIX_W:0]   w3;
    logic [PIX_W:0]   w4;
    logic [1:0]       col;
    logic [1:0]       row;
    logic [PIX_W-1:0] dx;
    logic [PIX_W:0]   dy;
    logic             in_rng;
    logic             tile;
    face_t            face_c;

    logic             a_valid_reg;
    logic             a_ok_reg;
    face_t            a_face_reg;
    logic [OFF_W-1:0] a_lx_reg;
    logic [OFF_W-1:0] a_ly_reg;

    logic [OFF_W+SPAN_W-1:0]     pu;
    logic [OFF_W+SPAN_W-1:0]     pv;
    logic signed [OFF_W+SPAN_W+1:0] tu;
    logic signed [OFF_W+SPAN_W+1:0] tv;
    logic signed [COMP_W-1:0]    u;
    logic signed [COMP_W-1:0]    v;
    item_t                       item_next;

    logic  b_valid_reg;
    item_t b_item_reg;

    assign en        = !b_valid_reg || q_ready;
    assign pix.ready = en;
    assign q_push    = b_valid_reg && q_ready;
    assign q_item    = b_item_reg;

    always_comb
    begin
        w  = (face_size > FS_W'(MAX_FACE_SIZE)) ? FS_W'(MAX_FACE_SIZE) : face_size;
        w2 = {w, 1'b0};
        w3 = (PIX_W+1)'(w2) + (PIX_W+1)'(w);
        w4 = {w, 2'b00};
        if (pix.pix_x >= w2)
        begin
            col = 2'd2;
            dx  = pix.pix_x - w2;
        end
        else if (pix.pix_x >= PIX_W'(w))
        begin
            col = 2'd1;
            dx  = pix.pix_x - PIX_W'(w);
        end
        else
        begin
            col = 2'd0;
            dx  = pix.pix_x;
        end
        if ({1'b0, pix.pix_y} >= w3)
        begin
            row = 2'd3;
            dy  = {1'b0, pix.pix_y} - w3;
        end
        else if ({1'b0, pix.pix_y} >= (PIX_W+1)'(w2))
        begin
            row = 2'd2;
            dy  = {1'b0, pix.pix_y} - (PIX_W+1)'(w2);
        end
        else if ({1'b0, pix.pix_y} >= (PIX_W+1)'(w))
        begin
            row = 2'd1;
            dy  = {1'b0, pix.pix_y} - (PIX_W+1)'(w);
        end
        else
        begin
            row = 2'd0;
            dy  = {1'b0, pix.pix_y};
        end
        in_rng = (w != '0) && ({1'b0, pix.pix_x} < w3) && ({1'b0, pix.pix_y} < w4);
        tile   = 1'b1;
        case ({row, col})
            4'b01_10: face_c = FACE_PX;
            4'b01_00: face_c = FACE_NX;
            4'b00_01: face_c = FACE_PY;
            4'b10_01: face_c = FACE_NY;
            4'b01_01: face_c = FACE_PZ;
            4'b11_01: face_c = FACE_NZ;
            default:
            begin
                face_c = FACE_PX;
                tile   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= pix.valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ok_reg   <= in_rng && tile;
            a_face_reg <= face_c;
            a_lx_reg   <= dx[OFF_W-1:0];
            a_ly_reg   <= dy[OFF_W-1:0];
            b_item_reg <= item_next;
        end
    end

    always_comb
    begin
        pu = OFF_W'(a_lx_reg) * inv_span;
        pv = OFF_W'(a_ly_reg) * inv_span;
        tu = $signed({1'b0, pu, 1'b0}) - (OFF_W+SPAN_W+2)'(ONE_Q24);
        tv = $signed({1'b0, pv, 1'b0}) - (OFF_W+SPAN_W+2)'(ONE_Q24);
        if (tu > (OFF_W+SPAN_W+2)'(ONE_Q24))
            u = ONE_Q24;
        else if (tu < -(OFF_W+SPAN_W+2)'(ONE_Q24))
            u = -ONE_Q24;
        else
            u = COMP_W'(tu);
        if (tv > (OFF_W+SPAN_W+2)'(ONE_Q24))
            v = ONE_Q24;
        else if (tv < -(OFF_W+SPAN_W+2)'(ONE_Q24))
            v = -ONE_Q24;
        else
            v = COMP_W'(tv);
        item_next.ok   = a_ok_reg;
        item_next.face = a_face_reg;
        case (a_face_reg)
            FACE_PX:
            begin
                item_next.a = ONE_Q24;  item_next.b = v;  item_next.c = -u;
            end
            FACE_NX:
            begin
                item_next.a = -ONE_Q24; item_next.b = v;  item_next.c = u;
            end
            FACE_PY:
            begin
                item_next.a = u;  item_next.b = -ONE_Q24; item_next.c = v;
            end
            FACE_NY:
            begin
                item_next.a = u;  item_next.b = ONE_Q24;  item_next.c = -v;
            end
            FACE_PZ:
            begin
                item_next.a = u;  item_next.b = v;  item_next.c = ONE_Q24;
            end
            FACE_NZ:
            begin
                item_next.a = -u; item_next.b = v;  item_next.c = -ONE_Q24;
            end
            default:
            begin
                item_next.a = '0; item_next.b = '0; item_next.c = '0;
            end
        endcase
        if (!a_ok_reg)
        begin
            item_next.face = FACE_PX;
            item_next.a    = '0;
            item_next.b    = '0;
            item_next.c    = '0;
        end
    end

endmodule

### hdl/cpcd_queue.sv
// Two-entry queue between the front end and the normalizer.
// Depends on cpcd_pkg.
module cpcd_queue
    import cpcd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t wr_item,
    input  logic  push,
    output logic  wr_ready,
    output item_t rd_item,
    output logic  rd_valid,
    input  logic  pop
);

    item_t      mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_item;
    end

endmodule

### hdl/cpcd_back.sv
// Normalizer: squares, pipelined integer square root, three pipelined dividers.
// Depends on cpcd_pkg and cpcd_if.
module cpcd_back
    import cpcd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  item_t    q_item,
    input  logic     q_valid,
    output logic     q_pop,
    cpcd_dir_if.source dir
);

    logic                 en;
    carry_t               sq_tag_next;
    logic [2:0][SQ_W-1:0] sq_next;

    logic                 sq_valid_reg;
    carry_t               sq_tag_reg;
    logic [2:0][SQ_W-1:0] sq_reg;

    logic        rt_valid_reg [RT_STEPS+1];
    carry_t      rt_tag_reg   [RT_STEPS+1];
    logic [RT_W-1:0] rt_n_reg [RT_STEPS+1];
    logic [RT_W-1:0] rt_r_reg [RT_STEPS+1];

    logic                    dv_valid_reg [DIV_STEPS+1];
    tag_t                    dv_tag_reg   [DIV_STEPS+1];
    logic [MAG_W-1:0]        dv_den_reg   [DIV_STEPS+1];
    logic [2:0][REM_W-1:0]   dv_rem_reg   [DIV_STEPS+1];
    logic [2:0][DIV_STEPS-1:0] dv_q_reg   [DIV_STEPS+1];

    logic                      out_valid_reg;
    logic                      out_ok_reg;
    face_t                     out_face_reg;
    logic [2:0][DIR_W-1:0]     out_dir_reg;
    logic [2:0][DIR_W-1:0]     out_dir_next;

    assign en    = !out_valid_reg || dir.ready;
    assign q_pop = en && q_valid;

    always_comb
    begin
        sq_tag_next.ok     = q_item.ok;
        sq_tag_next.face   = q_item.face;
        sq_tag_next.neg    = {q_item.c[COMP_W-1], q_item.b[COMP_W-1], q_item.a[COMP_W-1]};
        sq_tag_next.mag[0] = q_item.a[COMP_W-1] ? MAG_W'(-q_item.a) : q_item.a[MAG_W-1:0];
        sq_tag_next.mag[1] = q_item.b[COMP_W-1] ? MAG_W'(-q_item.b) : q_item.b[MAG_W-1:0];
        sq_tag_next.mag[2] = q_item.c[COMP_W-1] ? MAG_W'(-q_item.c) : q_item.c[MAG_W-1:0];
        for (int k = 0; k < 3; k++)
            sq_next[k] = SQ_W'(sq_tag_next.mag[k]) * SQ_W'(sq_tag_next.mag[k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg    <= 1'b0;
            rt_valid_reg[0] <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg    <= q_valid;
            rt_valid_reg[0] <= sq_valid_reg;
            dv_valid_reg[0] <= rt_valid_reg[RT_STEPS];
            out_valid_reg   <= dv_valid_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_tag_reg <= sq_tag_next;
            sq_reg     <= sq_next;
            rt_tag_reg[0] <= sq_tag_reg;
            rt_n_reg[0]   <= RT_W'(sq_reg[0]) + RT_W'(sq_reg[1]) + RT_W'(sq_reg[2]);
            rt_r_reg[0]   <= '0;
            dv_tag_reg[0].ok   <= rt_tag_reg[RT_STEPS].ok;
            dv_tag_reg[0].face <= rt_tag_reg[RT_STEPS].face;
            dv_tag_reg[0].neg  <= rt_tag_reg[RT_STEPS].neg;
            dv_den_reg[0]      <= rt_r_reg[RT_STEPS][MAG_W-1:0];
            for (int k = 0; k < 3; k++)
            begin
                dv_rem_reg[0][k] <= REM_W'({rt_tag_reg[RT_STEPS].mag[k], FRAC_OUT'(0)})
                                  + REM_W'(rt_r_reg[RT_STEPS][MAG_W-1:1]);
                dv_q_reg[0][k]   <= '0;
            end
            out_ok_reg   <= dv_tag_reg[DIV_STEPS].ok;
            out_face_reg <= dv_tag_reg[DIV_STEPS].ok ? dv_tag_reg[DIV_STEPS].face : FACE_PX;
            out_dir_reg  <= out_dir_next;
        end
    end

    for (genvar j = 0; j < RT_STEPS; j++)
    begin : g_rt
        localparam logic [RT_W-1:0] BIT = RT_W'(1) << (2 * (RT_STEPS - 1 - j));
        logic [RT_W-1:0] trial;
        assign trial = rt_r_reg[j] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rt_valid_reg[j+1] <= 1'b0;
            else if (en)
                rt_valid_reg[j+1] <= rt_valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_tag_reg[j+1] <= rt_tag_reg[j];
                if (rt_n_reg[j] >= trial)
                begin
                    rt_n_reg[j+1] <= rt_n_reg[j] - trial;
                    rt_r_reg[j+1] <= (rt_r_reg[j] >> 1) + BIT;
                end
                else
                begin
                    rt_n_reg[j+1] <= rt_n_reg[j];
                    rt_r_reg[j+1] <= rt_r_reg[j] >> 1;
                end
            end
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_dv
        localparam int SH = DIV_STEPS - 1 - j;
        logic [REM_W-1:0] dsh;
        assign dsh = REM_W'(dv_den_reg[j]) << SH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[j+1] <= 1'b0;
            else if (en)
                dv_valid_reg[j+1] <= dv_valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_tag_reg[j+1] <= dv_tag_reg[j];
                dv_den_reg[j+1] <= dv_den_reg[j];
                for (int k = 0; k < 3; k++)
                begin
                    if (dv_rem_reg[j][k] >= dsh)
                    begin
                        dv_rem_reg[j+1][k] <= dv_rem_reg[j][k] - dsh;
                        dv_q_reg[j+1][k]   <= dv_q_reg[j][k] | (DIV_STEPS'(1) << SH);
                    end
                    else
                    begin
                        dv_rem_reg[j+1][k] <= dv_rem_reg[j][k];
                        dv_q_reg[j+1][k]   <= dv_q_reg[j][k];
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (!dv_tag_reg[DIV_STEPS].ok)
                out_dir_next[k] = '0;
            else if (dv_tag_reg[DIV_STEPS].neg[k])
                out_dir_next[k] = -DIR_W'(dv_q_reg[DIV_STEPS][k]);
            else
                out_dir_next[k] = DIR_W'(dv_q_reg[DIV_STEPS][k]);
        end
    end

    assign dir.valid     = out_valid_reg;
    assign dir.valid_res = out_ok_reg;
    assign dir.face_code = out_face_reg;
    assign dir.dir_x     = out_dir_reg[0];
    assign dir.dir_y     = out_dir_reg[1];
    assign dir.dir_z     = out_dir_reg[2];

endmodule

### hdl/cross_pixel_to_cube_direction.sv
// Top level: vertical-cross cube map pixel to unit direction.
// Depends on cpcd_pkg, cpcd_if, cpcd_front, cpcd_queue, cpcd_back.
//
//  channel  dir  signals                                       transfer
//  pix      in   valid ready pix_x pix_y                       valid & ready
//  dir      out  valid ready valid_res face_code dir_x/y/z     valid & ready
//  cfg      in   cfg_we cfg_index cfg_data                     cfg_we high
//
// One pixel per cycle sustained while dir is ready; the normalizer holds
// the 25-stage square root and the 15-stage dividers.
// Reset restores face_size 256 and inv_span 65793; no clearing pass.
// A stall on dir holds the normalizer; the queue lets the front end keep
// accepting until it fills.
module cross_pixel_to_cube_direction
    import cpcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    cpcd_pix_if.sink              pix,
    cpcd_dir_if.source            dir
);

    logic [FS_W-1:0]   face_size_reg;
    logic [SPAN_W-1:0] inv_span_reg;

    item_t f_item;
    logic  q_push;
    logic  q_ready;
    item_t b_item;
    logic  b_valid;
    logic  b_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_size_reg <= FACE_SIZE_RST;
            inv_span_reg  <= INV_SPAN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FACE_SIZE: face_size_reg <= cfg_data[FS_W-1:0];
                REG_INV_SPAN:  inv_span_reg  <= cfg_data[SPAN_W-1:0];
                default:       face_size_reg <= face_size_reg;
            endcase
        end
    end

    cpcd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .face_size (face_size_reg),
        .inv_span  (inv_span_reg),
        .pix       (pix),
        .q_item    (f_item),
        .q_push    (q_push),
        .q_ready   (q_ready)
    );

    cpcd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_item  (f_item),
        .push     (q_push),
        .wr_ready (q_ready),
        .rd_item  (b_item),
        .rd_valid (b_valid),
        .pop      (b_pop)
    );

    cpcd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_item  (b_item),
        .q_valid (b_valid),
        .q_pop   (b_pop),
        .dir     (dir)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_ready)
        else $error("queue push while full");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dir.valid && !dir.valid_res |-> dir.face_code == FACE_PX && dir.dir_x == '0
            && dir.dir_y == '0 && dir.dir_z == '0)
        else $error("invalid result carries nonzero data");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        dir.valid && dir.valid_res |-> dir.dir_x <= DIR_ONE && dir.dir_x >= -DIR_ONE
            && dir.dir_y <= DIR_ONE && dir.dir_y >= -DIR_ONE
            && dir.dir_z <= DIR_ONE && dir.dir_z >= -DIR_ONE)
        else $error("direction component out of unit range");
`endif

endmodule
